// File: src/clnw_pkg.sv
// Shared types, codes and constants for the character-LCD nibble writer.
// No dependencies; imported by clnw_seq and char_lcd_nibble_writer.
`default_nettype none

package clnw_pkg;

    localparam int SETTLE_W  = 12;
    localparam int INDEX_W   = 7;
    localparam int COLUMN_W  = 5;
    localparam int CFG_IDX_W = 4;

    // Request codes.
    localparam logic [1:0] ACT_RAW    = 2'd0;
    localparam logic [1:0] ACT_TEXT   = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETTLE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_SETTLE = 4'd1;

    localparam logic [SETTLE_W-1:0] DATA_SETTLE_RESET    = 12'd50;
    localparam logic [SETTLE_W-1:0] COMMAND_SETTLE_RESET = 12'd2050;

    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] CMD_CURSOR_RIGHT = 8'h14;

    localparam logic [COLUMN_W-1:0] MAX_COLUMN = 5'd19;

    // Character positions that end a display line.
    localparam logic [INDEX_W-1:0] LINE0_END = 7'd19;
    localparam logic [INDEX_W-1:0] LINE1_END = 7'd39;
    localparam logic [INDEX_W-1:0] LINE2_END = 7'd59;
    localparam logic [INDEX_W-1:0] LINE3_END = 7'd79;

    function automatic logic [7:0] row_addr(input logic [1:0] r);
        logic [7:0] a;
        case (r)
            2'd0:    a = 8'h00;
            2'd1:    a = 8'h40;
            2'd2:    a = 8'h14;
            2'd3:    a = 8'h54;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

    // Everything the sequencer needs to start on one request.
    typedef struct packed {
        logic                rs;
        logic [7:0]          first_byte;
        logic                pend_valid;
        logic [7:0]          pend_byte;
        logic [COLUMN_W-1:0] shifts;
    } load_t;

    // One nibble strobe.
    typedef struct packed {
        logic                rs;
        logic [3:0]          nib;
        logic [SETTLE_W-1:0] settle;
        logic                last;
    } strobe_t;

endpackage

`default_nettype wire

// File: src/clnw_seq.sv
// Strobe sequencer: splits bytes into nibbles and repeats cursor-right commands
// with a down counter. Depends on clnw_pkg.
`default_nettype none

module clnw_seq
    import clnw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire load_t               load,
    input  wire logic                adv,
    input  wire logic [SETTLE_W-1:0] data_settle,
    input  wire logic [SETTLE_W-1:0] command_settle,
    output logic                     busy,
    output strobe_t                  strobe
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HIGH = 2'd1;
    localparam logic [1:0] ST_LOW  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                rs_reg, rs_next;
    logic [7:0]          byte_reg, byte_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_reg, pend_next;
    logic [COLUMN_W-1:0] shifts_reg, shifts_next;
    logic                done;

    assign busy = (state_reg != ST_IDLE);
    assign done = !pend_valid_reg && (shifts_reg == '0);

    always_comb
    begin
        strobe.rs = rs_reg;
        if (state_reg == ST_LOW)
        begin
            strobe.nib    = byte_reg[3:0];
            strobe.settle = rs_reg ? data_settle : command_settle;
            strobe.last   = done;
        end
        else
        begin
            strobe.nib    = byte_reg[7:4];
            strobe.settle = '0;
            strobe.last   = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rs_next         = rs_reg;
        byte_next       = byte_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        shifts_next     = shifts_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next      = ST_HIGH;
                    rs_next         = load.rs;
                    byte_next       = load.first_byte;
                    pend_valid_next = load.pend_valid;
                    pend_next       = load.pend_byte;
                    shifts_next     = load.shifts;
                end
            end
            ST_HIGH:
            begin
                if (adv)
                    state_next = ST_LOW;
            end
            ST_LOW:
            begin
                if (adv)
                begin
                    if (pend_valid_reg)
                    begin
                        state_next      = ST_HIGH;
                        rs_next         = 1'b0;
                        byte_next       = pend_reg;
                        pend_valid_next = 1'b0;
                    end
                    else if (shifts_reg != '0)
                    begin
                        // Each pass of the counter sends one cursor-right command.
                        state_next  = ST_HIGH;
                        rs_next     = 1'b0;
                        byte_next   = CMD_CURSOR_RIGHT;
                        shifts_next = shifts_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            shifts_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            shifts_reg     <= shifts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// File: src/char_lcd_nibble_writer.sv
// Top level of the character-LCD nibble writer: request decode, line-wrap index,
// settle registers and the output register. Depends on clnw_pkg and clnw_seq.
`default_nettype none

// Each accepted request is turned into nibble beats for a 4-bit character LCD,
// high nibble first, one beat per cycle while the output side takes them. A raw
// command or end of message gives 2 beats, a text character 2 or 4 (a line wrap
// adds a row-start address command), and a cursor move 2 + 2*min(column,19)
// beats, up to 40. The sequencer steps through these one beat at a time, and no
// new request is taken until its last beat has entered the output register.
// The output register lets the last beat wait for the consumer while the next
// request is accepted. Settle times are written through the configuration port
// (index 0 data, index 1 command); other indexes are ignored.
module char_lcd_nibble_writer
    import clnw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SETTLE_W-1:0]  cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [7:0]           byte_value,
    input  wire logic [COLUMN_W-1:0]  column,
    input  wire logic [1:0]           row,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      reg_select,
    output logic [3:0]                nibble,
    output logic [SETTLE_W-1:0]       settle_us,
    output logic                      last
);

    logic [SETTLE_W-1:0] data_settle_reg, command_settle_reg;
    logic [INDEX_W-1:0]  char_index_reg, char_index_next;
    logic                out_valid_reg;
    strobe_t             out_reg;
    load_t               load;
    strobe_t             strobe;
    logic                busy, start, adv;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign start     = in_valid && !busy;
    assign adv       = busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        load.rs         = 1'b0;
        load.first_byte = byte_value;
        load.pend_valid = 1'b0;
        load.pend_byte  = CMD_SET_DDRAM;
        load.shifts     = '0;
        char_index_next = char_index_reg;
        case (action)
            ACT_RAW:
            begin
                load.first_byte = byte_value;
            end
            ACT_TEXT:
            begin
                load.rs = 1'b1;
                if (char_index_reg >= LINE3_END)
                begin
                    load.pend_valid = 1'b1;
                    load.pend_byte  = CMD_SET_DDRAM | row_addr(2'd0);
                    char_index_next = '0;
                end
                else
                begin
                    if (char_index_reg == LINE0_END)
                    begin
                        load.pend_valid = 1'b1;
                        load.pend_byte  = CMD_SET_DDRAM | row_addr(2'd1);
                    end
                    else if (char_index_reg == LINE1_END)
                    begin
                        load.pend_valid = 1'b1;
                        load.pend_byte  = CMD_SET_DDRAM | row_addr(2'd2);
                    end
                    else if (char_index_reg == LINE2_END)
                    begin
                        load.pend_valid = 1'b1;
                        load.pend_byte  = CMD_SET_DDRAM | row_addr(2'd3);
                    end
                    char_index_next = char_index_reg + 1'b1;
                end
            end
            ACT_CURSOR:
            begin
                load.first_byte = CMD_SET_DDRAM | row_addr(row);
                load.shifts     = (column > MAX_COLUMN) ? MAX_COLUMN : column;
            end
            ACT_END:
            begin
                load.first_byte = CMD_SET_DDRAM | row_addr(2'd0);
                char_index_next = '0;
            end
            default:
            begin
                load.first_byte = byte_value;
            end
        endcase
    end

    clnw_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .load           (load),
        .adv            (adv),
        .data_settle    (data_settle_reg),
        .command_settle (command_settle_reg),
        .busy           (busy),
        .strobe         (strobe)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_settle_reg    <= DATA_SETTLE_RESET;
            command_settle_reg <= COMMAND_SETTLE_RESET;
            char_index_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_DATA_SETTLE)
                data_settle_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_COMMAND_SETTLE)
                command_settle_reg <= cfg_data;
            if (start)
                char_index_reg <= char_index_next;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= strobe;
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = out_reg.rs;
    assign nibble     = out_reg.nib;
    assign settle_us  = out_reg.settle;
    assign last       = out_reg.last;

endmodule

`default_nettype wire

// File: dv/tb_char_lcd_nibble_writer.sv
// Self-checking testbench for char_lcd_nibble_writer: directed and random requests,
// with every nibble beat checked against an in-bench prediction of the LCD link.
// Depends on clnw_pkg and the RTL under src; needs no files or arguments.
module tb_char_lcd_nibble_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import clnw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 4'd15;
    localparam logic [7:0] ROW_BASE [0:3] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_TAIL   = 16;
    localparam int STALL_LIMIT  = 2000;

    // Predicts the nibble beats of each request and holds them until they arrive.
    class lcd_beat_scoreboard;
        strobe_t             expected_beats[$];
        logic [SETTLE_W-1:0] data_settle;
        logic [SETTLE_W-1:0] command_settle;
        logic [INDEX_W-1:0]  char_pos;
        int unsigned         mismatches;
        int unsigned         beats_checked;
        int unsigned         requests;
        int unsigned         line_wraps;
        int unsigned         display_wraps;

        function new();
            data_settle    = DATA_SETTLE_RESET;
            command_settle = COMMAND_SETTLE_RESET;
            char_pos       = '0;
            mismatches     = 0;
            beats_checked  = 0;
            requests       = 0;
            line_wraps     = 0;
            display_wraps  = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [SETTLE_W-1:0] value);
            if (idx == CFG_DATA_SETTLE)
                data_settle = value;
            else if (idx == CFG_COMMAND_SETTLE)
                command_settle = value;
        endfunction

        function void push_byte(input logic rs, input logic [7:0] value,
                                input logic [SETTLE_W-1:0] settle);
            strobe_t beat;
            beat.rs     = rs;
            beat.nib    = value[7:4];
            beat.settle = '0;
            beat.last   = 1'b0;
            expected_beats.push_back(beat);
            beat.nib    = value[3:0];
            beat.settle = settle;
            expected_beats.push_back(beat);
        endfunction

        function void push_command(input logic [7:0] value);
            push_byte(1'b0, value, command_settle);
        endfunction

        function void note_request(input logic [1:0] act, input logic [7:0] value,
                                   input logic [COLUMN_W-1:0] col, input logic [1:0] r);
            logic [COLUMN_W-1:0] shifts;
            requests++;
            case (act)
                ACT_RAW: push_command(value);
                ACT_TEXT:
                begin
                    push_byte(1'b1, value, data_settle);
                    // At the end of the last line the cursor returns to the top left.
                    if (char_pos >= LINE3_END)
                    begin
                        push_command(CMD_SET_DDRAM | ROW_BASE[0]);
                        char_pos = '0;
                        display_wraps++;
                    end
                    else
                    begin
                        if (char_pos == LINE0_END)
                        begin
                            push_command(CMD_SET_DDRAM | ROW_BASE[1]);
                            line_wraps++;
                        end
                        else if (char_pos == LINE1_END)
                        begin
                            push_command(CMD_SET_DDRAM | ROW_BASE[2]);
                            line_wraps++;
                        end
                        else if (char_pos == LINE2_END)
                        begin
                            push_command(CMD_SET_DDRAM | ROW_BASE[3]);
                            line_wraps++;
                        end
                        char_pos = char_pos + 7'd1;
                    end
                end
                ACT_CURSOR:
                begin
                    push_command(CMD_SET_DDRAM | ROW_BASE[r]);
                    shifts = (col > MAX_COLUMN) ? MAX_COLUMN : col;
                    repeat (shifts) push_command(CMD_CURSOR_RIGHT);
                end
                default:
                begin
                    push_command(CMD_SET_DDRAM | ROW_BASE[0]);
                    char_pos = '0;
                end
            endcase
            expected_beats[expected_beats.size() - 1].last = 1'b1;
        endfunction

        function void check_beat(input logic rs, input logic [3:0] nib,
                                 input logic [SETTLE_W-1:0] settle, input logic fin);
            strobe_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: reg_select %0d nibble %0h settle_us %0d last %0d",
                       rs, nib, settle, fin);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (rs !== want.rs)
            begin
                $error("reg_select: expected %0d, actual %0d", want.rs, rs);
                mismatches++;
            end
            if (nib !== want.nib)
            begin
                $error("nibble: expected %0h, actual %0h", want.nib, nib);
                mismatches++;
            end
            if (settle !== want.settle)
            begin
                $error("settle_us: expected %0d, actual %0d", want.settle, settle);
                mismatches++;
            end
            if (fin !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, fin);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SETTLE_W-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           action = ACT_RAW;
    logic [7:0]           byte_value = '0;
    logic [COLUMN_W-1:0]  column = '0;
    logic [1:0]           row = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 reg_select;
    logic [3:0]           nibble;
    logic [SETTLE_W-1:0]  settle_us;
    logic                 last;

    lcd_beat_scoreboard   sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          stall_cycles = 0;

    char_lcd_nibble_writer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .settle_us  (settle_us),
        .last       (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Output side: check each accepted beat, then decide whether to stall next cycle.
    always @(posedge clk)
    begin
        if (sb != null && rst_n && out_valid && out_ready)
            sb.check_beat(reg_select, nibble, settle_us, last);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_char_lcd_nibble_writer failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_request(input logic [1:0] act, input logic [7:0] value,
                                input logic [COLUMN_W-1:0] col, input logic [1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        byte_value <= value;
        column     <= col;
        row        <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(act, value, col, r);
    endtask

    // Long messages are almost all text so that the index runs through every line end.
    task automatic send_random(input bit long_message);
        int unsigned         pick;
        logic [1:0]          act;
        logic [COLUMN_W-1:0] col;
        pick = $urandom_range(99);
        if (long_message)
            act = (pick < 92) ? ACT_TEXT : (pick < 96) ? ACT_RAW : ACT_CURSOR;
        else
            act = (pick < 50) ? ACT_TEXT : (pick < 65) ? ACT_RAW :
                  (pick < 90) ? ACT_CURSOR : ACT_END;
        if ($urandom_range(4) == 0)
            col = 5'($urandom_range(31, 20));
        else
            col = 5'($urandom_range(19));
        send_request(act, 8'($urandom_range(255)), col, 2'($urandom_range(3)));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SETTLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 59;

        // Directed part under the reset settle values.
        send_request(ACT_RAW, 8'h00, 5'd0, 2'd0);
        send_request(ACT_RAW, 8'hFF, 5'd31, 2'd3);
        send_request(ACT_RAW, 8'hA5, 5'd0, 2'd0);
        send_request(ACT_TEXT, 8'h00, 5'd0, 2'd0);
        send_request(ACT_TEXT, 8'hFF, 5'd0, 2'd0);
        send_request(ACT_CURSOR, 8'h00, 5'd0, 2'd0);
        send_request(ACT_CURSOR, 8'h00, 5'd1, 2'd1);
        send_request(ACT_CURSOR, 8'h00, 5'd19, 2'd1);
        send_request(ACT_CURSOR, 8'hFF, 5'd20, 2'd2);
        send_request(ACT_CURSOR, 8'h00, 5'd31, 2'd3);
        send_request(ACT_END, 8'h00, 5'd0, 2'd0);
        send_request(ACT_TEXT, 8'h41, 5'd0, 2'd0);
        send_request(ACT_RAW, 8'h5A, 5'd0, 2'd0);
        send_request(ACT_END, 8'hFF, 5'd31, 2'd3);
        drain();

        write_register(CFG_DATA_SETTLE, 12'd0);
        write_register(CFG_COMMAND_SETTLE, 12'hFFF);
        write_register(CFG_UNUSED_TOP, 12'($urandom_range(4095)));
        repeat (5) send_random(1'b0);
        drain();

        send_idle_pct = 59;
        recv_idle_pct = 19;
        write_register(CFG_DATA_SETTLE, 12'hFFF);
        write_register(CFG_COMMAND_SETTLE, 12'd0);
        write_register(CFG_UNUSED_LOW, 12'($urandom_range(4095)));
        send_request(ACT_END, 8'($urandom_range(255)), 5'd0, 2'd0);
        sent = 0;
        while (sent < 80 || sb.display_wraps == 0)
        begin
            send_random(1'b1);
            sent++;
        end
        send_request(ACT_END, 8'($urandom_range(255)), 5'd0, 2'd0);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_DATA_SETTLE, 12'($urandom_range(4095)));
        write_register(CFG_COMMAND_SETTLE, 12'($urandom_range(4095)));
        repeat (5) send_random(1'b0);
        drain();

        if (sb.pending() != 0)
        begin
            $error("%0d expected beats never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Checked %0d beats from %0d requests, with %0d line wraps and %0d",
                 sb.beats_checked, sb.requests, sb.line_wraps, sb.display_wraps);
        $display("full-display wraps, over four settle settings and three idle mixes.");
        if (sb.mismatches == 0)
            $display("tb_char_lcd_nibble_writer passed");
        else
            $display("tb_char_lcd_nibble_writer failed");
        $finish;
    end
endmodule

// File: sim.f
src/clnw_pkg.sv
src/clnw_seq.sv
src/char_lcd_nibble_writer.sv
dv/tb_char_lcd_nibble_writer.sv
